FILE: hdl/apu_tfs_pkg.sv
// ----------------------------------------------------------------------------
// apu_tfs_pkg
// Shared types and constants for the audio frame sequencer and its bench.
// ----------------------------------------------------------------------------
package apu_tfs_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FOUR_STEP_MODE = 2'd0,
        CFG_IRQ_INHIBIT    = 2'd1,
        CFG_FRAME_PERIOD   = 2'd2,
        CFG_SAMPLE_PERIOD  = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIV_W      = 16;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned CLK_CNT_W  = 2;

    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [DIV_W-1:0]      div_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [CLK_CNT_W-1:0]  clk_cnt_t;

    // sequence lengths
    localparam step_t FOUR_STEP_LEN = 3'd4;
    localparam step_t FIVE_STEP_LEN = 3'd5;

    // step numbers with special meaning
    localparam step_t STEP_ONE   = 3'd1;
    localparam step_t STEP_THREE = 3'd3;
    localparam step_t STEP_FOUR  = 3'd4;

    // register reset values
    localparam logic RST_FOUR_STEP_MODE = 1'b1;
    localparam logic RST_IRQ_INHIBIT    = 1'b0;
    localparam div_t RST_FRAME_PERIOD   = 16'd7457;
    localparam div_t RST_SAMPLE_PERIOD  = 16'd40;

endpackage

FILE: hdl/apu_tick_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// apu_tick_frame_sequencer_core
// Frame sequencer and channel clock distributor of a console audio unit.
// ----------------------------------------------------------------------------
// Each input item is one CPU tick and yields exactly one result item. The
// result is computed combinationally from the accepted item and the
// sequencer state (tick parity, frame and sample dividers, step number) and
// lands in the output register as the item is accepted. A new item is
// taken every cycle while the output register is empty or being drained, so
// the sustained rate is one item per clock; the state update is the only
// loop. Configuration writes apply at once and take effect from the next
// accepted item.
module apu_tick_frame_sequencer_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write_en,
    input  apu_tfs_pkg::cfg_index_t cfg_index,
    input  apu_tfs_pkg::cfg_data_t cfg_data,
    // tick items
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   frame_write,
    // result items
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             square_clocks,
    output logic [1:0]             triangle_clocks,
    output logic                   quarter_frame,
    output logic [1:0]             half_frame_count,
    output logic                   irq_set,
    output logic                   sample_strobe
);
    import apu_tfs_pkg::*;

    // configuration registers
    logic four_step_mode_reg;
    logic irq_inhibit_reg;
    div_t frame_period_reg;
    div_t sample_period_reg;

    // sequencer state
    logic  tick_parity_reg,    tick_parity_next;
    div_t  frame_divider_reg,  frame_divider_next;
    div_t  sample_divider_reg, sample_divider_next;
    step_t step_number_reg,    step_number_next;

    // result register
    logic     out_valid_reg;
    clk_cnt_t square_clocks_reg,    square_clocks_next;
    clk_cnt_t triangle_clocks_reg,  triangle_clocks_next;
    logic     quarter_frame_reg,    quarter_frame_next;
    clk_cnt_t half_frame_reg,       half_frame_next;
    logic     irq_set_reg,          irq_set_next;
    logic     sample_strobe_reg,    sample_strobe_next;

    logic  accept;
    logic  even_tick;
    logic  frame_fire;
    div_t  frame_eff_period;
    div_t  sample_eff_period;
    div_t  frame_div_inc;
    div_t  sample_div_inc;
    step_t seq_len;
    step_t cur_step;
    step_t inc_step;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_step_mode_reg <= RST_FOUR_STEP_MODE;
            irq_inhibit_reg    <= RST_IRQ_INHIBIT;
            frame_period_reg   <= RST_FRAME_PERIOD;
            sample_period_reg  <= RST_SAMPLE_PERIOD;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FOUR_STEP_MODE: four_step_mode_reg <= cfg_data[0];
                CFG_IRQ_INHIBIT:    irq_inhibit_reg    <= cfg_data[0];
                CFG_FRAME_PERIOD:   frame_period_reg   <= cfg_data[DIV_W-1:0];
                CFG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data[DIV_W-1:0];
                default:            ;
            endcase
        end
    end

    // dividers: fire at zero, zero period acts as one
    always_comb
    begin
        frame_eff_period  = (frame_period_reg == '0) ? div_t'(1) : frame_period_reg;
        sample_eff_period = (sample_period_reg == '0) ? div_t'(1) : sample_period_reg;
        frame_div_inc     = frame_divider_reg + div_t'(1);
        sample_div_inc    = sample_divider_reg + div_t'(1);

        frame_fire          = (frame_divider_reg == '0);
        frame_divider_next  = (frame_div_inc >= frame_eff_period) ? '0 : frame_div_inc;
        sample_divider_next = (sample_div_inc >= sample_eff_period) ? '0 : sample_div_inc;
        sample_strobe_next  = (sample_divider_reg == '0);
        tick_parity_next    = !tick_parity_reg;
    end

    // step sequence and result fields
    always_comb
    begin
        even_tick = !tick_parity_reg;
        seq_len   = four_step_mode_reg ? FOUR_STEP_LEN : FIVE_STEP_LEN;
        cur_step  = (step_number_reg >= seq_len) ? '0 : step_number_reg;
        inc_step  = cur_step + step_t'(1);

        square_clocks_next   = {frame_write && even_tick, even_tick && !frame_write};
        triangle_clocks_next = {frame_write, !frame_write};
        quarter_frame_next   = 1'b0;
        irq_set_next         = 1'b0;
        half_frame_next      = {1'b0, frame_write};
        step_number_next     = step_number_reg;

        if (frame_fire)
        begin
            if (four_step_mode_reg)
            begin
                quarter_frame_next = 1'b1;
                if (cur_step == STEP_ONE || cur_step == STEP_THREE)
                begin
                    half_frame_next = half_frame_next + clk_cnt_t'(1);
                end
                irq_set_next = (cur_step == STEP_THREE) && !irq_inhibit_reg;
            end
            else
            begin
                quarter_frame_next = (cur_step != STEP_THREE);
                if (cur_step == STEP_ONE || cur_step == STEP_FOUR)
                begin
                    half_frame_next = half_frame_next + clk_cnt_t'(1);
                end
            end
            step_number_next = (inc_step >= seq_len) ? '0 : inc_step;
        end
    end

    // state advances once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_parity_reg    <= 1'b0;
            frame_divider_reg  <= '0;
            sample_divider_reg <= '0;
            step_number_reg    <= '0;
        end
        else if (accept)
        begin
            tick_parity_reg    <= tick_parity_next;
            frame_divider_reg  <= frame_divider_next;
            sample_divider_reg <= sample_divider_next;
            step_number_reg    <= step_number_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            square_clocks_reg   <= square_clocks_next;
            triangle_clocks_reg <= triangle_clocks_next;
            quarter_frame_reg   <= quarter_frame_next;
            half_frame_reg      <= half_frame_next;
            irq_set_reg         <= irq_set_next;
            sample_strobe_reg   <= sample_strobe_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign square_clocks    = square_clocks_reg;
    assign triangle_clocks  = triangle_clocks_reg;
    assign quarter_frame    = quarter_frame_reg;
    assign half_frame_count = half_frame_reg;
    assign irq_set          = irq_set_reg;
    assign sample_strobe    = sample_strobe_reg;

endmodule

FILE: hdl/apu_tfs_checker.sv
// ----------------------------------------------------------------------------
// apu_tfs_checker
// Port-level checks on the frame sequencer, bound into the sequencer core.
// ----------------------------------------------------------------------------
module apu_tfs_checker
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [1:0]              square_clocks,
    input logic [1:0]              triangle_clocks,
    input logic                    quarter_frame,
    input logic [1:0]              half_frame_count,
    input logic                    irq_set,
    input logic                    sample_strobe
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(square_clocks)
            && $stable(triangle_clocks) && $stable(half_frame_count)
            && $stable(irq_set) && $stable(quarter_frame) && $stable(sample_strobe))
        else $error("result item changed while stalled");

    // triangle_clocks only ever holds 1 or 2
    a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (triangle_clocks == 2'd1 || triangle_clocks == 2'd2))
        else $error("triangle clock count out of range");

    // with a frame-counter write, square_clocks is 0 or 2 and half_frame_count is nonzero
    a_write_effect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && triangle_clocks == 2'd2
            |-> half_frame_count != 2'd0 && square_clocks != 2'd1)
        else $error("frame write effects inconsistent");

    // without a write the squares get at most one clock and at most one half frame
    a_plain_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && triangle_clocks == 2'd1
            |-> square_clocks != 2'd2 && square_clocks != 2'd3 && half_frame_count != 2'd2
                && half_frame_count != 2'd3)
        else $error("plain tick gives too many clocks");

    // the frame interrupt only comes with a quarter and half frame step
    a_irq_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_set |-> quarter_frame && half_frame_count != 2'd0)
        else $error("frame interrupt outside the last four-step step");

endmodule

bind apu_tick_frame_sequencer_core apu_tfs_checker u_apu_tfs_checker (.*);

FILE: bench/tb_apu_tick_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// tb_apu_tick_frame_sequencer_core
// Self-checking bench for the frame sequencer and channel clock distributor.
// ----------------------------------------------------------------------------
// Every tick item sent in is run through a cycle-accurate software copy of
// the sequencer (tick parity, frame and sample dividers, step number), and
// each result item coming out is checked field by field against the oldest
// prediction. A short directed plan walks reset behavior, register extremes,
// frame-counter writes, period lowering and stale step numbers across a mode
// change; random phases with fresh register settings follow. Both handshake
// sides idle at random, with some phases running flat out.
module tb_apu_tick_frame_sequencer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import apu_tfs_pkg::*;

    // one result item, in port order
    typedef struct packed {
        clk_cnt_t square_clocks;
        clk_cnt_t triangle_clocks;
        logic     quarter_frame;
        clk_cnt_t half_frame_count;
        logic     irq_set;
        logic     sample_strobe;
    } tick_result_t;

    typedef enum logic {
        ROW_TICK,
        ROW_REG
    } row_op_t;

    typedef struct packed {
        row_op_t      op;
        cfg_index_t   reg_idx;
        cfg_data_t    reg_value;
        logic         frame_write;
        logic         pinned;
        tick_result_t result;
    } plan_row_t;

    localparam int PLAN_ROWS    = 36;
    localparam int RANDOM_TICKS = 1700;
    localparam int DRAIN_CYCLES = 16;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_write_en;
    cfg_index_t   cfg_index;
    cfg_data_t    cfg_data;
    logic         in_valid;
    logic         in_ready;
    logic         frame_write;
    logic         out_valid;
    logic         out_ready;
    logic [1:0]   square_clocks;
    logic [1:0]   triangle_clocks;
    logic         quarter_frame;
    logic [1:0]   half_frame_count;
    logic         irq_set;
    logic         sample_strobe;

    // sequencer copy: registers and state
    logic         seq_four_step;
    logic         seq_irq_inhibit;
    div_t         seq_frame_period;
    div_t         seq_sample_period;
    logic         seq_parity;
    div_t         seq_frame_div;
    div_t         seq_sample_div;
    step_t        seq_step;

    tick_result_t predicted_ticks[$];
    logic         pin_valid;
    tick_result_t pin_result;
    logic         no_idle;

    int fail_count;
    int ticks_sent;
    int results_checked;
    int quarter_seen;
    int irq_seen;
    int strobe_seen;
    int settings_used;

    // directed plan: reset behavior, frame writes, period lowering, irq
    // inhibit, five-step run ending on step four, stale step after mode
    // change, zero and full-scale periods
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b1, '{2'd1, 2'd1, 1'b1, 2'd0, 1'b0, 1'b1}},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b1, '{2'd0, 2'd2, 1'b0, 2'd1, 1'b0, 1'b0}},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b1, '{2'd2, 2'd2, 1'b0, 2'd1, 1'b0, 1'b0}},
        '{ROW_REG,  CFG_FRAME_PERIOD,   16'd1, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_SAMPLE_PERIOD,  16'd1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_IRQ_INHIBIT,    16'd1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_FOUR_STEP_MODE, 16'd1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b0, '0},
        '{ROW_REG,  CFG_FRAME_PERIOD,   16'd0, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_SAMPLE_PERIOD,  16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b0, '0},
        '{ROW_REG,  CFG_FRAME_PERIOD,   16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_SAMPLE_PERIOD,  16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_FOUR_STEP_MODE, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_IRQ_INHIBIT,    16'd0, 1'b0, 1'b0, '0}
    };

    apu_tick_frame_sequencer_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .frame_write      (frame_write),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .square_clocks    (square_clocks),
        .triangle_clocks  (triangle_clocks),
        .quarter_frame    (quarter_frame),
        .half_frame_count (half_frame_count),
        .irq_set          (irq_set),
        .sample_strobe    (sample_strobe)
    );

    always #4 clk = ~clk;

    // divider count after one advance; a zero period behaves as one
    function automatic div_t next_divider(input div_t count, input div_t period);
        div_t limit;
        div_t next;
        limit = (period == '0) ? div_t'(1) : period;
        next  = count + div_t'(1);
        if (next >= limit)
            next = '0;
        return next;
    endfunction

    // advance the sequencer copy by one tick and return what it gives
    function automatic tick_result_t clock_one_tick(input logic fw);
        tick_result_t r;
        logic         even;
        step_t        seq_len;
        step_t        s;
        even                = ~seq_parity;
        r.square_clocks     = clk_cnt_t'(even) + clk_cnt_t'(fw & even);
        r.triangle_clocks   = clk_cnt_t'(1) + clk_cnt_t'(fw);
        r.quarter_frame     = 1'b0;
        r.half_frame_count  = clk_cnt_t'(fw);
        r.irq_set           = 1'b0;
        if (seq_frame_div == '0)
        begin
            seq_len = seq_four_step ? FOUR_STEP_LEN : FIVE_STEP_LEN;
            s = seq_step;
            // a step left over from the other mode restarts the sequence
            if (s >= seq_len)
                s = '0;
            if (seq_four_step)
            begin
                r.quarter_frame = 1'b1;
                if (s == STEP_ONE || s == STEP_THREE)
                    r.half_frame_count = r.half_frame_count + 2'd1;
                if (s == STEP_THREE && !seq_irq_inhibit)
                    r.irq_set = 1'b1;
            end
            else
            begin
                if (s != STEP_THREE)
                    r.quarter_frame = 1'b1;
                if (s == STEP_ONE || s == STEP_FOUR)
                    r.half_frame_count = r.half_frame_count + 2'd1;
            end
            s = s + step_t'(1);
            if (s >= seq_len)
                s = '0;
            seq_step = s;
        end
        seq_frame_div   = next_divider(seq_frame_div, seq_frame_period);
        r.sample_strobe = (seq_sample_div == '0);
        seq_sample_div  = next_divider(seq_sample_div, seq_sample_period);
        seq_parity      = ~seq_parity;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_pause();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // period choice leaning to short values so steps happen often
    function automatic cfg_data_t pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18)
            return cfg_data_t'(1);
        if (r < 60)
            return cfg_data_t'($urandom_range(2, 8));
        if (r < 85)
            return cfg_data_t'($urandom_range(9, 64));
        if (r < 95)
            return cfg_data_t'($urandom_range(65, 3000));
        if (r < 98)
            return 16'hFFFF;
        return cfg_data_t'($urandom_range(0, 65535));
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // register write once no item is in flight; enable stays high until the
    // next item or write so that back-to-back writes need no toggle
    task automatic write_reg(input cfg_index_t idx, input cfg_data_t value);
        if (in_valid)
            in_valid <= 1'b0;
        if (predicted_ticks.size() != 0)
        begin
            while (predicted_ticks.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        case (idx)
            CFG_FOUR_STEP_MODE: seq_four_step     = value[0];
            CFG_IRQ_INHIBIT:    seq_irq_inhibit   = value[0];
            CFG_FRAME_PERIOD:   seq_frame_period  = value;
            CFG_SAMPLE_PERIOD:  seq_sample_period = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // send one tick item, optionally with a typed-in expectation
    task automatic send_tick(input logic fw, input logic pinned, input tick_result_t pin);
        int gap;
        gap = pick_pause();
        if (cfg_write_en)
            cfg_write_en <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_write <= fw;
        pin_valid   = pinned;
        pin_result  = pin;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    // result side: random stalls
    initial
    begin
        int hold;
        out_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                hold = pick_pause();
            end
        end
    end

    // check results, then predict for a newly accepted item
    always @(posedge clk)
    begin
        tick_result_t got;
        tick_result_t want;
        tick_result_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{square_clocks, triangle_clocks, quarter_frame,
                        half_frame_count, irq_set, sample_strobe};
                if (predicted_ticks.size() == 0)
                begin
                    $error("result item arrived with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    want = predicted_ticks.pop_front();
                    check_field("square_clocks", want.square_clocks, got.square_clocks);
                    check_field("triangle_clocks", want.triangle_clocks,
                                got.triangle_clocks);
                    check_field("quarter_frame", want.quarter_frame, got.quarter_frame);
                    check_field("half_frame_count", want.half_frame_count,
                                got.half_frame_count);
                    check_field("irq_set", want.irq_set, got.irq_set);
                    check_field("sample_strobe", want.sample_strobe, got.sample_strobe);
                    results_checked++;
                    quarter_seen += got.quarter_frame;
                    irq_seen     += got.irq_set;
                    strobe_seen  += got.sample_strobe;
                end
            end
            if (in_valid && in_ready)
            begin
                pred = clock_one_tick(frame_write);
                predicted_ticks.push_back(pin_valid ? pin_result : pred);
            end
        end
    end

    // main sequence
    initial
    begin
        int random_ticks;
        int phase_len;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_FOUR_STEP_MODE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        frame_write  = 1'b0;
        pin_valid    = 1'b0;
        pin_result   = '0;
        no_idle      = 1'b0;
        fail_count      = 0;
        ticks_sent      = 0;
        results_checked = 0;
        quarter_seen    = 0;
        irq_seen        = 0;
        strobe_seen     = 0;
        settings_used   = 1;
        random_ticks    = 0;
        seq_four_step     = RST_FOUR_STEP_MODE;
        seq_irq_inhibit   = RST_IRQ_INHIBIT;
        seq_frame_period  = RST_FRAME_PERIOD;
        seq_sample_period = RST_SAMPLE_PERIOD;
        seq_parity        = 1'b0;
        seq_frame_div     = '0;
        seq_sample_div    = '0;
        seq_step          = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed plan
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].op == ROW_REG)
            begin
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_value);
                settings_used++;
            end
            else
                send_tick(directed_plan[i].frame_write, directed_plan[i].pinned,
                          directed_plan[i].result);
        end

        // random phases, each under a fresh register setting
        while (random_ticks < RANDOM_TICKS)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_FOUR_STEP_MODE, cfg_data_t'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_IRQ_INHIBIT, cfg_data_t'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_FRAME_PERIOD, pick_period());
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_SAMPLE_PERIOD, pick_period());
            settings_used++;
            phase_len = $urandom_range(10, 80);
            repeat (phase_len)
            begin
                send_tick($urandom_range(0, 3) == 0, 1'b0, '0);
                random_ticks++;
            end
        end
        no_idle = 1'b0;

        // drain
        if (cfg_write_en)
            cfg_write_en <= 1'b0;
        in_valid <= 1'b0;
        while (predicted_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_used, results_checked);
        $display("seen: %0d quarter frames, %0d frame irqs, %0d sample strobes",
                 quarter_seen, irq_seen, strobe_seen);
        if (fail_count == 0)
            $display("apu_tick_frame_sequencer_core verification clean");
        else
            $display("apu_tick_frame_sequencer_core verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("apu_tick_frame_sequencer_core verification failed");
        $finish;
    end

endmodule

FILE: apu_tick_frame_sequencer_core.f
hdl/apu_tfs_pkg.sv
hdl/apu_tick_frame_sequencer_core.sv
hdl/apu_tfs_checker.sv
bench/tb_apu_tick_frame_sequencer_core.sv
